[design/slid_pkg.sv]
`default_nettype none
package slid_pkg;

    localparam int OP_W     = 1;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic load;    // register the compare flags against the probe key
        logic commit;  // apply the update this cycle
        logic ins;     // update is an insert
        logic del;     // update is a delete of a found key
    } cell_cmd_t;

endpackage
`default_nettype wire

[design/slid_if.sv]
`default_nettype none
interface slid_in_if;
    import slid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface slid_out_if;
    import slid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] smallest_key;
    logic [COUNT_W-1:0]      entry_count;

    modport source (output valid, output status, output smallest_key, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input smallest_key, input entry_count,
                    output ready);
endinterface
`default_nettype wire

[design/slid_cell.sv]
`default_nettype none
module slid_cell #(
    parameter int KEY_BITS = 32,
    parameter int CNT_W    = 7,
    parameter int IDX      = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire slid_pkg::cell_cmd_t cmd,
    input  wire logic [KEY_BITS-1:0] probe,
    input  wire logic [CNT_W-1:0]    count,
    input  wire logic [KEY_BITS-1:0] left_key,
    input  wire logic                left_lt,
    input  wire logic [KEY_BITS-1:0] right_key,
    output logic [KEY_BITS-1:0]      key_q,
    output logic [KEY_BITS-1:0]      key_next,
    output logic                     lt_q,
    output logic                     hit_q
);
    import slid_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [KEY_BITS-1:0] key_reg;
    logic                lt_reg;
    logic                eq_reg;
    logic                live;

    assign live = (IDX_C < count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            lt_reg <= live && ($signed(key_reg) < $signed(probe));
            eq_reg <= live && (key_reg == probe);
        end
    end

    // Cells below the insert or delete point keep their key; the rest shift.
    always_comb
    begin
        key_next = key_reg;
        if (cmd.commit && cmd.ins)
        begin
            if (!lt_reg)
            begin
                key_next = left_lt ? probe : left_key;
            end
        end
        else if (cmd.commit && cmd.del)
        begin
            if (!lt_reg)
            begin
                key_next = right_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;
    // This cell is the first not-smaller entry and holds the probe key.
    assign hit_q = eq_reg && !lt_reg && left_lt;

endmodule
`default_nettype wire

[design/sorted_list_insert_delete_top.sv]
`default_nettype none
// Sorted key store: keeps up to CAPACITY signed KEY_BITS-wide keys in ascending order in a
// chain of cells, each holding one key and its compare flags. An insert goes ahead of the
// first stored key that is not smaller; a delete removes the first equal key. Each item
// takes these steps from acceptance to the next acceptance: the item is registered, every
// cell compares its key with the probe key, and the found flag is gathered across the
// chain while every cell shifts toward or away from its neighbor at once. The result is
// held in an output register, and the next item is taken while it waits; the update of
// that next item holds until the output register is free.
// Stored keys have no reset; only entries below the count are ever used.
module sorted_list_insert_delete_top #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    slid_in_if.sink     item_in,
    slid_out_if.source  result_out
);
    import slid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_BITS-1:0] probe_reg;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KEY_W-1:0]    smallest_reg, smallest_next;
    logic [COUNT_W-1:0]  ecount_reg;

    cell_cmd_t           cmd;
    logic                slot_free;
    logic                found;
    logic                full;
    logic                empty;

    logic [KEY_BITS-1:0] key_q    [CAPACITY];
    logic [KEY_BITS-1:0] key_next [CAPACITY];
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] hit_vec;

    logic [KEY_BITS+KEY_W-1:0] key_in_ext;
    logic [KEY_BITS+KEY_W-1:0] smallest_ext;
    logic [CNT_W+COUNT_W-1:0]  count_ext;

    // Key field bits above KEY_BITS are dropped; narrower fields are sign-extended.
    assign key_in_ext = {{KEY_BITS{item_in.key[KEY_W-1]}}, item_in.key};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KEY_BITS-1:0] left_key;
            logic                left_lt;
            logic [KEY_BITS-1:0] right_key;

            if (g == 0)
            begin : g_first
                assign left_key = probe_reg;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_mid
                assign left_key = key_q[g-1];
                assign left_lt  = lt_vec[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_key = key_q[g];
            end
            else
            begin : g_inner
                assign right_key = key_q[g+1];
            end

            slid_cell #(
                .KEY_BITS (KEY_BITS),
                .CNT_W    (CNT_W),
                .IDX      (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .probe     (probe_reg),
                .count     (count_reg),
                .left_key  (left_key),
                .left_lt   (left_lt),
                .right_key (right_key),
                .key_q     (key_q[g]),
                .key_next  (key_next[g]),
                .lt_q      (lt_vec[g]),
                .hit_q     (hit_vec[g])
            );
        end
    endgenerate

    assign found     = |hit_vec;
    assign full      = (count_reg == CAP_C);
    assign empty     = (count_reg == '0);
    assign slot_free = !out_valid_reg || result_out.ready;

    always_comb
    begin
        cmd.load   = (state_reg == ST_CMP);
        cmd.commit = (state_reg == ST_UPD) && slot_free;
        cmd.ins    = (op_reg == OP_INSERT) && !full;
        cmd.del    = (op_reg == OP_DELETE) && found;
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_DONE;
        if (op_reg == OP_INSERT)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else if (!found)
            begin
                status_next = STATUS_NOT_FOUND;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    assign smallest_ext  = {{KEY_W{key_next[0][KEY_BITS-1]}}, key_next[0]};
    assign smallest_next = (count_next == '0) ? '0 : smallest_ext[KEY_W-1:0];
    assign count_ext     = {{COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_in.valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            op_reg    <= item_in.op;
            probe_reg <= key_in_ext[KEY_BITS-1:0];
        end
        if (cmd.commit)
        begin
            status_reg   <= status_next;
            smallest_reg <= smallest_next;
            ecount_reg   <= count_ext[COUNT_W-1:0];
        end
    end

    assign item_in.ready           = (state_reg == ST_IDLE);
    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = status_reg;
    assign result_out.smallest_key = smallest_reg;
    assign result_out.entry_count  = ecount_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("stored count above capacity");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_UPD)
        else $error("result appeared without an update cycle");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(cmd.commit))
        else $error("count changed outside a commit");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd.ins) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count by one");

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> $onehot0(hit_vec))
        else $error("more than one cell claims the delete point");

endmodule
`default_nettype wire
